// ===== rtl/bpdc_pkg.sv =====
package bpdc_pkg;

    localparam int MAX_PERIODS      = 1024;
    localparam int RESULT_FRAC_BITS = 24;

    // opcodes
    localparam logic [1:0] OP_PRICE     = 2'd0;
    localparam logic [1:0] OP_MACAULAY  = 2'd1;
    localparam logic [1:0] OP_MODIFIED  = 2'd2;
    localparam logic [1:0] OP_CONVEXITY = 2'd3;

    // result status
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_NONPOS  = 2'd2;
    localparam logic [1:0] STAT_SAT     = 2'd3;

    localparam logic [63:0] ONE_Q56 = 64'h0100_0000_0000_0000;
    localparam logic [63:0] ONE_Q48 = 64'h0001_0000_0000_0000;
    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

    // divider iteration counts
    localparam logic [7:0] DIV_IT_INT   = 8'd64;
    localparam logic [7:0] DIV_IT_RECIP = 8'd113;
    localparam logic [7:0] DIV_IT_RATIO = 8'(128 + RESULT_FRAC_BITS);
    localparam logic [7:0] DIV_IT_YIELD = 8'd120;

    localparam int PRICE_SH = 76 - RESULT_FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE,
        S_YPM,
        S_DINV,
        S_LMUL_D,
        S_LMUL_T,
        S_LMUL_TT,
        S_CMUL,
        S_CDIV,
        S_FD,
        S_SC0,
        S_PRICE,
        S_SC1,
        S_FN,
        S_NUM,
        S_Q,
        S_QY1,
        S_QY2,
        S_QF,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic         start;
        logic [1:0]   last_i;
        logic         last_j;
        logic [127:0] a;
        logic [63:0]  b;
        logic [191:0] acc_init;
    } mul_req_t;

    typedef struct packed {
        logic         start;
        logic [7:0]   iters;
        logic [127:0] num;
        logic [127:0] den;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== rtl/bpdc_if.sv =====
interface bpdc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [31:0]        principal;
    logic signed [31:0] annual_coupon;
    logic signed [31:0] annual_yield;
    logic [10:0]        period_count;
    logic [3:0]         coupons_per_year;

    modport source (
        output valid, opcode, principal, annual_coupon, annual_yield,
               period_count, coupons_per_year,
        input  ready
    );
    modport sink (
        input  valid, opcode, principal, annual_coupon, annual_yield,
               period_count, coupons_per_year,
        output ready
    );
endinterface

interface bpdc_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] metric_value;
    logic [1:0]         status;

    modport source (
        output valid, metric_value, status,
        input  ready
    );
    modport sink (
        input  valid, metric_value, status,
        output ready
    );
endinterface

// ===== rtl/bpdc_mulacc.sv =====
module bpdc_mulacc (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bpdc_pkg::mul_req_t    req,
    output bpdc_pkg::unit_stat_t  stat,
    output logic [191:0]          acc
);

    logic [127:0] a_reg;
    logic [63:0]  b_reg;
    logic [1:0]   last_i_reg;
    logic         last_j_reg;
    logic [1:0]   i_reg;
    logic         j_reg;
    logic [191:0] acc_reg;
    logic [63:0]  prod_reg;
    logic [2:0]   pshift_reg;
    logic         pv_reg;
    logic         run_reg;
    logic         done_reg;

    logic [31:0]  a_word;
    logic [31:0]  b_word;
    logic [191:0] addend;

    assign a_word = a_reg[{i_reg, 5'b0} +: 32];
    assign b_word = b_reg[{j_reg, 5'b0} +: 32];
    assign addend = {128'b0, prod_reg} << {pshift_reg, 5'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= 2'd0;
            j_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                pv_reg  <= 1'b0;
                i_reg   <= 2'd0;
                j_reg   <= 1'b0;
            end
            else if (run_reg)
            begin
                pv_reg <= 1'b1;
                if (j_reg == last_j_reg)
                begin
                    j_reg <= 1'b0;
                    if (i_reg == last_i_reg)
                        run_reg <= 1'b0;
                    else
                        i_reg <= i_reg + 2'd1;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            else if (pv_reg)
            begin
                // last partial product folded in this cycle
                pv_reg   <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg      <= req.a;
            b_reg      <= req.b;
            last_i_reg <= req.last_i;
            last_j_reg <= req.last_j;
            acc_reg    <= req.acc_init;
        end
        else
        begin
            if (pv_reg)
                acc_reg <= acc_reg + addend;
            if (run_reg)
            begin
                prod_reg   <= a_word * b_word;
                pshift_reg <= {1'b0, i_reg} + {2'b0, j_reg};
            end
        end
    end

    assign stat.busy = run_reg | pv_reg;
    assign stat.done = done_reg;
    assign acc       = acc_reg;

endmodule

// ===== rtl/bpdc_div.sv =====
module bpdc_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bpdc_pkg::div_req_t    req,
    output bpdc_pkg::unit_stat_t  stat,
    output logic [63:0]           q,
    output logic                  ovf
);

    logic [127:0] num_reg;
    logic [127:0] rem_reg;
    logic [127:0] den_reg;
    logic [63:0]  q_reg;
    logic         ovf_reg;
    logic [7:0]   cnt_reg;
    logic         run_reg;
    logic         done_reg;

    logic [127:0] shifted;
    logic [127:0] diff;
    logic         qb;

    assign shifted = {rem_reg[126:0], num_reg[127]};
    assign diff    = shifted - den_reg;
    // a set top bit means the shifted remainder exceeds any 128-bit divisor
    assign qb      = rem_reg[127] | (shifted >= den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 8'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= req.iters;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 8'd1;
                if (cnt_reg == 8'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= 128'd0;
            q_reg   <= 64'd0;
            ovf_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[126:0], 1'b0};
            rem_reg <= qb ? diff : shifted;
            q_reg   <= {q_reg[62:0], qb};
            if (q_reg[63])
                ovf_reg <= 1'b1;
        end
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign q         = q_reg;
    assign ovf       = ovf_reg;

endmodule

// ===== rtl/bond_price_duration_convexity.sv =====
// Bond price, Macaulay duration, modified duration and convexity.
// item (sink): one beat per bond: opcode, principal in cents, Q4.28 coupon
// and yield, period count n and coupons per year f.
// result (source): one beat per item: signed Q40.24 metric_value and status
// (ok, invalid input, non-positive price, saturated).
// Items are handled one at a time; item.ready is high only while the
// sequencer is idle. The period walk runs on one shared 32x32 multiplier,
// four partial products for the discount step and two each for the t and
// t(t+1) weighted sums. The restoring divider produces one quotient bit
// per cycle; convexity runs more divisions than price. Inputs that fail
// the item check skip the period walk and go straight to the result.
// The result sits in an output register; a new item is accepted while it
// waits, and the sequencer holds its next result until result.ready frees
// the register. Reset returns the sequencer to idle and drops result.valid.
module bond_price_duration_convexity (
    input  logic        clk,
    input  logic        rst_n,
    bpdc_in_if.sink     item,
    bpdc_out_if.source  result
);

    bpdc_pkg::seq_state_t state_reg, state_next;
    logic         wait_reg, wait_next;
    logic [1:0]   op_reg, op_next;
    logic [31:0]  prin_reg, prin_next;
    logic         cneg_reg, cneg_next;
    logic [31:0]  cabs_reg, cabs_next;
    logic         yneg_reg, yneg_next;
    logic [31:0]  yabs_reg, yabs_next;
    logic [10:0]  n_reg, n_next;
    logic [3:0]   f_reg, f_next;
    logic [63:0]  onep_reg, onep_next;
    logic [63:0]  d_reg, d_next;
    logic [63:0]  dt_reg, dt_next;
    logic [10:0]  t_reg, t_next;
    logic [20:0]  tt_reg, tt_next;
    logic [127:0] s0_reg, s0_next;
    logic [127:0] s1_reg, s1_next;
    logic [127:0] s2_reg, s2_next;
    logic [63:0]  cmag_reg, cmag_next;
    logic [127:0] fd_reg, fd_next;
    logic [127:0] sc_reg, sc_next;
    logic [127:0] fn_reg, fn_next;
    logic [127:0] pr_reg, pr_next;
    logic         nneg_reg, nneg_next;
    logic [63:0]  q_reg, q_next;
    logic         ovf_reg, ovf_next;
    logic [63:0]  res_val_reg, res_val_next;
    logic [1:0]   res_st_reg, res_st_next;
    logic         out_vld_reg, out_vld_next;
    logic [63:0]  out_val_reg, out_val_next;
    logic [1:0]   out_st_reg, out_st_next;

    bpdc_pkg::mul_req_t   mul_req;
    bpdc_pkg::unit_stat_t mul_stat;
    logic [191:0]         mul_acc;
    bpdc_pkg::div_req_t   div_req;
    bpdc_pkg::unit_stat_t div_stat;
    logic [63:0]          div_q;
    logic                 div_ovf;

    // shared signed add: sc_reg carries the coupon sign, the other side is >= 0
    logic [127:0] ss_b;
    logic [128:0] ss_sum;
    logic [128:0] ss_ba;
    logic [127:0] ss_ab;
    logic [127:0] ss_res;
    logic         ss_neg;
    logic         ss_ovf;

    logic [127:0] pr_shift;
    logic [7:0]   ff;
    logic         item_bad;
    logic [65:0]  em;
    logic [63:0]  em_mag;
    logic         em_neg;
    logic         em_ovf;

    function automatic logic [65:0] emit_f(input logic [63:0] mag, input logic neg,
                                           input logic ovf);
        logic [65:0] r;
        if (!neg)
        begin
            if (ovf || mag[63])
                r = {bpdc_pkg::STAT_SAT, bpdc_pkg::POS_MAX};
            else
                r = {bpdc_pkg::STAT_OK, mag};
        end
        else
        begin
            if (ovf || (mag > bpdc_pkg::NEG_MIN))
                r = {bpdc_pkg::STAT_SAT, bpdc_pkg::NEG_MIN};
            else
                r = {bpdc_pkg::STAT_OK, ~mag + 64'd1};
        end
        return r;
    endfunction

    bpdc_mulacc u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .stat  (mul_stat),
        .acc   (mul_acc)
    );

    bpdc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat),
        .q     (div_q),
        .ovf   (div_ovf)
    );

    assign ss_b   = (state_reg == bpdc_pkg::S_NUM) ? fn_reg : fd_reg;
    assign ss_sum = {1'b0, sc_reg} + {1'b0, ss_b};
    assign ss_ba  = {1'b0, ss_b} - {1'b0, sc_reg};
    assign ss_ab  = sc_reg - ss_b;

    always_comb
    begin
        if (!cneg_reg)
        begin
            ss_res = ss_sum[127:0];
            ss_neg = 1'b0;
            ss_ovf = ss_sum[128];
        end
        else if (!ss_ba[128])
        begin
            ss_res = ss_ba[127:0];
            ss_neg = 1'b0;
            ss_ovf = 1'b0;
        end
        else
        begin
            ss_res = ss_ab;
            ss_neg = 1'b1;
            ss_ovf = 1'b0;
        end
    end

    assign pr_shift = ss_res >> bpdc_pkg::PRICE_SH;
    assign ff       = {4'b0, f_reg} * {4'b0, f_reg};
    assign item_bad = (item.period_count == 11'd0) || (item.coupons_per_year == 4'd0) ||
                      (item.period_count > 11'(bpdc_pkg::MAX_PERIODS));

    always_comb
    begin
        if (state_reg == bpdc_pkg::S_PRICE)
        begin
            em_mag = pr_shift[63:0];
            em_neg = ss_neg;
            em_ovf = |pr_shift[127:64];
        end
        else
        begin
            em_mag = div_q;
            em_neg = nneg_reg;
            em_ovf = ovf_reg | div_ovf;
        end
    end

    assign em = emit_f(em_mag, em_neg, em_ovf);

    // unit operand select
    always_comb
    begin
        mul_req = '0;
        div_req = '0;
        case (state_reg)
            bpdc_pkg::S_LMUL_D:
            begin
                mul_req.a      = {64'b0, dt_reg};
                mul_req.b      = d_reg;
                mul_req.last_i = 2'd1;
                mul_req.last_j = 1'b1;
            end
            bpdc_pkg::S_LMUL_T:
            begin
                mul_req.a        = {64'b0, dt_reg};
                mul_req.b        = {53'b0, t_reg};
                mul_req.last_i   = 2'd1;
                mul_req.acc_init = {64'b0, s1_reg};
            end
            bpdc_pkg::S_LMUL_TT:
            begin
                mul_req.a        = {64'b0, dt_reg};
                mul_req.b        = {43'b0, tt_reg};
                mul_req.last_i   = 2'd1;
                mul_req.acc_init = {64'b0, s2_reg};
            end
            bpdc_pkg::S_CMUL:
            begin
                mul_req.a = {96'b0, prin_reg};
                mul_req.b = {32'b0, cabs_reg};
            end
            bpdc_pkg::S_FD:
            begin
                mul_req.a      = {68'b0, prin_reg, 28'b0};
                mul_req.b      = dt_reg;
                mul_req.last_i = 2'd1;
                mul_req.last_j = 1'b1;
            end
            bpdc_pkg::S_SC0:
            begin
                mul_req.a      = s0_reg;
                mul_req.b      = cmag_reg;
                mul_req.last_i = 2'd3;
                mul_req.last_j = 1'b1;
            end
            bpdc_pkg::S_SC1:
            begin
                mul_req.a      = (op_reg == bpdc_pkg::OP_CONVEXITY) ? s2_reg : s1_reg;
                mul_req.b      = cmag_reg;
                mul_req.last_i = 2'd3;
                mul_req.last_j = 1'b1;
            end
            bpdc_pkg::S_FN:
            begin
                mul_req.a      = fd_reg;
                mul_req.b      = (op_reg == bpdc_pkg::OP_CONVEXITY) ? {43'b0, tt_reg}
                                                                    : {53'b0, n_reg};
                mul_req.last_i = 2'd3;
            end
            bpdc_pkg::S_YPM:
            begin
                div_req.num   = {4'b0, yabs_reg, 28'b0, 64'b0};
                div_req.den   = {124'b0, f_reg};
                div_req.iters = bpdc_pkg::DIV_IT_INT;
            end
            bpdc_pkg::S_CDIV:
            begin
                div_req.num   = {cmag_reg, 64'b0};
                div_req.den   = {124'b0, f_reg};
                div_req.iters = bpdc_pkg::DIV_IT_INT;
            end
            bpdc_pkg::S_DINV:
            begin
                // 2^112 / (1 + y/f): only the single set bit is shifted in
                div_req.num   = {1'b1, 127'b0};
                div_req.den   = {64'b0, onep_reg};
                div_req.iters = bpdc_pkg::DIV_IT_RECIP;
            end
            bpdc_pkg::S_Q:
            begin
                div_req.num   = sc_reg;
                div_req.den   = pr_reg;
                div_req.iters = bpdc_pkg::DIV_IT_RATIO;
            end
            bpdc_pkg::S_QY1, bpdc_pkg::S_QY2:
            begin
                div_req.num   = {q_reg, 64'b0};
                div_req.den   = {64'b0, onep_reg};
                div_req.iters = bpdc_pkg::DIV_IT_YIELD;
            end
            bpdc_pkg::S_QF:
            begin
                div_req.num   = {q_reg, 64'b0};
                div_req.den   = (op_reg == bpdc_pkg::OP_CONVEXITY) ? {120'b0, ff}
                                                                   : {124'b0, f_reg};
                div_req.iters = bpdc_pkg::DIV_IT_INT;
            end
            default:
            begin
            end
        endcase
        case (state_reg)
            bpdc_pkg::S_LMUL_D, bpdc_pkg::S_LMUL_T, bpdc_pkg::S_LMUL_TT,
            bpdc_pkg::S_CMUL, bpdc_pkg::S_FD, bpdc_pkg::S_SC0,
            bpdc_pkg::S_SC1, bpdc_pkg::S_FN:
                mul_req.start = !wait_reg;
            bpdc_pkg::S_YPM, bpdc_pkg::S_CDIV, bpdc_pkg::S_DINV, bpdc_pkg::S_Q,
            bpdc_pkg::S_QY1, bpdc_pkg::S_QY2, bpdc_pkg::S_QF:
                div_req.start = !wait_reg;
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        wait_next    = wait_reg;
        op_next      = op_reg;
        prin_next    = prin_reg;
        cneg_next    = cneg_reg;
        cabs_next    = cabs_reg;
        yneg_next    = yneg_reg;
        yabs_next    = yabs_reg;
        n_next       = n_reg;
        f_next       = f_reg;
        onep_next    = onep_reg;
        d_next       = d_reg;
        dt_next      = dt_reg;
        t_next       = t_reg;
        tt_next      = tt_reg;
        s0_next      = s0_reg;
        s1_next      = s1_reg;
        s2_next      = s2_reg;
        cmag_next    = cmag_reg;
        fd_next      = fd_reg;
        sc_next      = sc_reg;
        fn_next      = fn_reg;
        pr_next      = pr_reg;
        nneg_next    = nneg_reg;
        q_next       = q_reg;
        ovf_next     = ovf_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        out_val_next = out_val_reg;
        out_st_next  = out_st_reg;
        out_vld_next = out_vld_reg & ~result.ready;

        if (mul_req.start || div_req.start)
            wait_next = 1'b1;

        case (state_reg)
            bpdc_pkg::S_IDLE:
            begin
                if (item.valid)
                begin
                    op_next   = item.opcode;
                    prin_next = item.principal;
                    cneg_next = item.annual_coupon[31];
                    cabs_next = item.annual_coupon[31] ? (~item.annual_coupon + 32'd1)
                                                       : item.annual_coupon;
                    yneg_next = item.annual_yield[31];
                    yabs_next = item.annual_yield[31] ? (~item.annual_yield + 32'd1)
                                                      : item.annual_yield;
                    n_next    = item.period_count;
                    f_next    = item.coupons_per_year;
                    ovf_next  = 1'b0;
                    wait_next = 1'b0;
                    if (item_bad)
                    begin
                        res_val_next = 64'd0;
                        res_st_next  = bpdc_pkg::STAT_INVALID;
                        state_next   = bpdc_pkg::S_OUT;
                    end
                    else
                    begin
                        state_next = bpdc_pkg::S_YPM;
                    end
                end
            end
            bpdc_pkg::S_YPM:
            begin
                if (wait_reg && div_stat.done)
                begin
                    wait_next = 1'b0;
                    if (yneg_reg && (div_q >= bpdc_pkg::ONE_Q56))
                    begin
                        res_val_next = 64'd0;
                        res_st_next  = bpdc_pkg::STAT_INVALID;
                        state_next   = bpdc_pkg::S_OUT;
                    end
                    else
                    begin
                        onep_next  = yneg_reg ? (bpdc_pkg::ONE_Q56 - div_q)
                                              : (bpdc_pkg::ONE_Q56 + div_q);
                        state_next = bpdc_pkg::S_DINV;
                    end
                end
            end
            bpdc_pkg::S_DINV:
            begin
                if (wait_reg && div_stat.done)
                begin
                    wait_next = 1'b0;
                    if (div_ovf)
                    begin
                        res_val_next = bpdc_pkg::POS_MAX;
                        res_st_next  = bpdc_pkg::STAT_SAT;
                        state_next   = bpdc_pkg::S_OUT;
                    end
                    else
                    begin
                        d_next     = div_q;
                        dt_next    = bpdc_pkg::ONE_Q48;
                        t_next     = 11'd1;
                        tt_next    = 21'd2;
                        s0_next    = 128'd0;
                        s1_next    = 128'd0;
                        s2_next    = 128'd0;
                        state_next = bpdc_pkg::S_LMUL_D;
                    end
                end
            end
            bpdc_pkg::S_LMUL_D:
            begin
                if (wait_reg && mul_stat.done)
                begin
                    wait_next = 1'b0;
                    // D_t must stay below 2^64 after the Q.56 realign
                    if (|mul_acc[127:120])
                    begin
                        res_val_next = bpdc_pkg::POS_MAX;
                        res_st_next  = bpdc_pkg::STAT_SAT;
                        state_next   = bpdc_pkg::S_OUT;
                    end
                    else
                    begin
                        dt_next    = mul_acc[119:56];
                        s0_next    = s0_reg + {64'b0, mul_acc[119:56]};
                        state_next = bpdc_pkg::S_LMUL_T;
                    end
                end
            end
            bpdc_pkg::S_LMUL_T:
            begin
                if (wait_reg && mul_stat.done)
                begin
                    wait_next  = 1'b0;
                    s1_next    = mul_acc[127:0];
                    state_next = bpdc_pkg::S_LMUL_TT;
                end
            end
            bpdc_pkg::S_LMUL_TT:
            begin
                if (wait_reg && mul_stat.done)
                begin
                    wait_next = 1'b0;
                    s2_next   = mul_acc[127:0];
                    if (t_reg == n_reg)
                    begin
                        // tt_reg now holds n(n+1)
                        state_next = bpdc_pkg::S_CMUL;
                    end
                    else
                    begin
                        t_next     = t_reg + 11'd1;
                        tt_next    = tt_reg + {9'b0, t_reg + 11'd1, 1'b0};
                        state_next = bpdc_pkg::S_LMUL_D;
                    end
                end
            end
            bpdc_pkg::S_CMUL:
            begin
                if (wait_reg && mul_stat.done)
                begin
                    wait_next  = 1'b0;
                    cmag_next  = mul_acc[63:0];
                    state_next = bpdc_pkg::S_CDIV;
                end
            end
            bpdc_pkg::S_CDIV:
            begin
                if (wait_reg && div_stat.done)
                begin
                    wait_next  = 1'b0;
                    cmag_next  = div_q;
                    state_next = bpdc_pkg::S_FD;
                end
            end
            bpdc_pkg::S_FD:
            begin
                if (wait_reg && mul_stat.done)
                begin
                    wait_next  = 1'b0;
                    fd_next    = mul_acc[127:0];
                    state_next = bpdc_pkg::S_SC0;
                end
            end
            bpdc_pkg::S_SC0:
            begin
                if (wait_reg && mul_stat.done)
                begin
                    wait_next  = 1'b0;
                    sc_next    = mul_acc[127:0];
                    ovf_next   = ovf_reg | (|mul_acc[191:128]);
                    state_next = bpdc_pkg::S_PRICE;
                end
            end
            bpdc_pkg::S_PRICE:
            begin
                if (ovf_reg || ss_ovf)
                begin
                    res_val_next = bpdc_pkg::POS_MAX;
                    res_st_next  = bpdc_pkg::STAT_SAT;
                    state_next   = bpdc_pkg::S_OUT;
                end
                else if (op_reg == bpdc_pkg::OP_PRICE)
                begin
                    res_val_next = em[63:0];
                    res_st_next  = em[65:64];
                    state_next   = bpdc_pkg::S_OUT;
                end
                else if (ss_neg || (ss_res == 128'd0))
                begin
                    res_val_next = 64'd0;
                    res_st_next  = bpdc_pkg::STAT_NONPOS;
                    state_next   = bpdc_pkg::S_OUT;
                end
                else
                begin
                    pr_next    = ss_res;
                    wait_next  = 1'b0;
                    state_next = bpdc_pkg::S_SC1;
                end
            end
            bpdc_pkg::S_SC1:
            begin
                if (wait_reg && mul_stat.done)
                begin
                    wait_next  = 1'b0;
                    sc_next    = mul_acc[127:0];
                    ovf_next   = ovf_reg | (|mul_acc[191:128]);
                    state_next = bpdc_pkg::S_FN;
                end
            end
            bpdc_pkg::S_FN:
            begin
                if (wait_reg && mul_stat.done)
                begin
                    wait_next  = 1'b0;
                    fn_next    = mul_acc[127:0];
                    ovf_next   = ovf_reg | (|mul_acc[191:128]);
                    state_next = bpdc_pkg::S_NUM;
                end
            end
            bpdc_pkg::S_NUM:
            begin
                if (ovf_reg || ss_ovf)
                begin
                    res_val_next = bpdc_pkg::POS_MAX;
                    res_st_next  = bpdc_pkg::STAT_SAT;
                    state_next   = bpdc_pkg::S_OUT;
                end
                else
                begin
                    sc_next    = ss_res;
                    nneg_next  = ss_neg;
                    wait_next  = 1'b0;
                    state_next = bpdc_pkg::S_Q;
                end
            end
            bpdc_pkg::S_Q:
            begin
                if (wait_reg && div_stat.done)
                begin
                    wait_next  = 1'b0;
                    q_next     = div_q;
                    ovf_next   = ovf_reg | div_ovf;
                    state_next = (op_reg == bpdc_pkg::OP_MACAULAY) ? bpdc_pkg::S_QF
                                                                   : bpdc_pkg::S_QY1;
                end
            end
            bpdc_pkg::S_QY1:
            begin
                if (wait_reg && div_stat.done)
                begin
                    wait_next  = 1'b0;
                    q_next     = div_q;
                    ovf_next   = ovf_reg | div_ovf;
                    state_next = (op_reg == bpdc_pkg::OP_CONVEXITY) ? bpdc_pkg::S_QY2
                                                                    : bpdc_pkg::S_QF;
                end
            end
            bpdc_pkg::S_QY2:
            begin
                if (wait_reg && div_stat.done)
                begin
                    wait_next  = 1'b0;
                    q_next     = div_q;
                    ovf_next   = ovf_reg | div_ovf;
                    state_next = bpdc_pkg::S_QF;
                end
            end
            bpdc_pkg::S_QF:
            begin
                if (wait_reg && div_stat.done)
                begin
                    wait_next    = 1'b0;
                    res_val_next = em[63:0];
                    res_st_next  = em[65:64];
                    state_next   = bpdc_pkg::S_OUT;
                end
            end
            bpdc_pkg::S_OUT:
            begin
                if (!out_vld_reg || result.ready)
                begin
                    out_vld_next = 1'b1;
                    out_val_next = res_val_reg;
                    out_st_next  = res_st_reg;
                    state_next   = bpdc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bpdc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bpdc_pkg::S_IDLE;
            wait_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wait_reg    <= wait_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        prin_reg    <= prin_next;
        cneg_reg    <= cneg_next;
        cabs_reg    <= cabs_next;
        yneg_reg    <= yneg_next;
        yabs_reg    <= yabs_next;
        n_reg       <= n_next;
        f_reg       <= f_next;
        onep_reg    <= onep_next;
        d_reg       <= d_next;
        dt_reg      <= dt_next;
        t_reg       <= t_next;
        tt_reg      <= tt_next;
        s0_reg      <= s0_next;
        s1_reg      <= s1_next;
        s2_reg      <= s2_next;
        cmag_reg    <= cmag_next;
        fd_reg      <= fd_next;
        sc_reg      <= sc_next;
        fn_reg      <= fn_next;
        pr_reg      <= pr_next;
        nneg_reg    <= nneg_next;
        q_reg       <= q_next;
        ovf_reg     <= ovf_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
    end

    assign item.ready          = (state_reg == bpdc_pkg::S_IDLE);
    assign result.valid        = out_vld_reg;
    assign result.metric_value = out_val_reg;
    assign result.status       = out_st_reg;

    a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_loop_t: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bpdc_pkg::S_LMUL_D) |-> (t_reg != 11'd0 && t_reg <= n_reg))
        else $error("period index out of range");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("second item accepted while busy");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status == bpdc_pkg::STAT_INVALID ||
                          result.status == bpdc_pkg::STAT_NONPOS))
        |-> (result.metric_value == 64'sd0))
        else $error("error result carries a value");

endmodule
